FILE: hdl/cfa_pkg.sv
// Package: shared constants, types and controller commands for the contiguous fit allocator.
package cfa_pkg;

  localparam int MapUnits  = 256;
  localparam int MaxOwners = 16;
  localparam int UnitW     = $clog2(MapUnits);       // unit index
  localparam int CntW      = $clog2(MapUnits + 1);   // unit count incl. MapUnits
  localparam int OwnW      = $clog2(MaxOwners);
  localparam int OcntW     = $clog2(MaxOwners + 1);

  localparam logic [2:0] StAlloc    = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StFreed    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic [1:0] PolBest  = 2'd1;
  localparam logic [1:0] PolWorst = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_MARK, S_LOOK, S_CLEAR, S_SHIFT, S_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the item, reset scan
    logic scan_step;  // examine one unit
    logic mark_step;  // write one unit of the block
    logic alloc_done; // append table entry
    logic look_step;  // compare one table entry
    logic shift_step; // close the gap left by the freed entry
    logic set_result; // latch result fields
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clearing;
    logic is_free;
    logic table_full;
    logic bad_size;
    logic scan_done;
    logic found;
    logic mark_done;
    logic look_hit;
    logic look_done;
    logic shift_done;
  } sts_t;

endpackage

FILE: hdl/cfa_datapath.sv
// Datapath: used map, process table, hole scanner and result registers.
module cfa_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfa_pkg::cmd_t          cmd_i,
  output cfa_pkg::sts_t          sts_o,
  input  logic [8:0]             ram_size_i,
  input  logic                   action_i,
  input  logic [15:0]            owner_id_i,
  input  logic [8:0]             request_size_i,
  input  logic [1:0]             policy_i,
  output logic [2:0]             status_o,
  output logic [7:0]             start_address_o,
  output logic [7:0]             end_address_o
);
  import cfa_pkg::*;

  logic                 map_q [MapUnits];
  logic                 map_rd_q;
  logic                 clr_busy_q;
  logic [UnitW-1:0]     clr_idx_q;
  logic [15:0]          tab_own_q [MaxOwners];
  logic [UnitW-1:0]     tab_start_q [MaxOwners];
  logic [CntW-1:0]      tab_len_q [MaxOwners];
  logic [OcntW-1:0]     cnt_q;

  logic                 act_q;
  logic [15:0]          own_q;
  logic [CntW-1:0]      size_q;
  logic [1:0]           pol_q;
  logic [CntW-1:0]      lim_q;

  logic [CntW-1:0]      idx_q;     // scan / mark counter
  logic [CntW-1:0]      run_q;     // start of current run
  logic                 inrun_q;
  logic                 found_q;
  logic [CntW-1:0]      bstart_q;
  logic [CntW-1:0]      blen_q;
  logic [OwnW:0]        k_q;       // table look / shift index
  logic [CntW-1:0]      fstart_q;
  logic [CntW-1:0]      flen_q;
  logic [2:0]           status_q;
  logic [7:0]           sa_q, ea_q;

  logic                 unit_free;
  logic [CntW-1:0]      len;
  logic                 take;
  logic [OwnW-1:0]      k_idx;
  logic [UnitW-1:0]     u_idx;
  logic [CntW-1:0]      idx_nxt;
  logic [UnitW-1:0]     rd_addr;

  assign u_idx     = idx_q[UnitW-1:0];
  assign k_idx     = k_q[OwnW-1:0];
  assign idx_nxt   = idx_q + CntW'(1);
  // Fetch the unit that the scan looks at in the next cycle.
  assign rd_addr   = cmd_i.scan_step ? idx_nxt[UnitW-1:0] : u_idx;
  assign unit_free = (idx_q < lim_q) && !map_rd_q;
  assign len       = idx_q - run_q;

  always_comb begin
    take = 1'b0;
    if (inrun_q && !unit_free && len >= size_q) begin
      if (!found_q)              take = 1'b1;
      else if (pol_q == PolBest)  take = len < blen_q;
      else if (pol_q == PolWorst) take = len > blen_q;
    end
  end

  always_comb begin
    sts_o.clearing   = clr_busy_q;
    sts_o.is_free    = act_q;
    sts_o.table_full = cnt_q == OcntW'(MaxOwners);
    sts_o.bad_size   = size_q == '0;
    sts_o.scan_done  = idx_q == lim_q;
    sts_o.found      = found_q || take;
    sts_o.mark_done  = idx_q == bstart_q + size_q - CntW'(1);
    sts_o.look_hit   = (k_q < (OwnW+1)'(cnt_q)) && tab_own_q[k_idx] == own_q;
    sts_o.look_done  = k_q >= (OwnW+1)'(cnt_q);
    sts_o.shift_done = k_q + (OwnW+1)'(1) >= (OwnW+1)'(cnt_q);
  end

  // Walk the whole map once after reset, one unit per cycle, marking it free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + UnitW'(1);
      if (clr_idx_q == UnitW'(MapUnits - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Map; unit writes beyond the depth are dropped.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      map_q[clr_idx_q] <= 1'b0;
    end else if (cmd_i.mark_step && idx_q < CntW'(MapUnits)) begin
      map_q[u_idx] <= !act_q;
    end
    map_rd_q <= map_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.alloc_done) begin
      cnt_q <= cnt_q + OcntW'(1);
    end else if (cmd_i.shift_step && sts_o.shift_done) begin
      cnt_q <= cnt_q - OcntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_done) begin
      tab_own_q[cnt_q[OwnW-1:0]]   <= own_q;
      tab_start_q[cnt_q[OwnW-1:0]] <= bstart_q[UnitW-1:0];
      tab_len_q[cnt_q[OwnW-1:0]]   <= size_q;
    end else if (cmd_i.shift_step && !sts_o.shift_done) begin
      tab_own_q[k_idx]   <= tab_own_q[k_idx + OwnW'(1)];
      tab_start_q[k_idx] <= tab_start_q[k_idx + OwnW'(1)];
      tab_len_q[k_idx]   <= tab_len_q[k_idx + OwnW'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      own_q   <= owner_id_i;
      size_q  <= request_size_i;
      pol_q   <= policy_i;
      lim_q   <= (ram_size_i > 9'(MapUnits)) ? CntW'(MapUnits) : CntW'(ram_size_i);
      idx_q   <= '0;
      inrun_q <= 1'b0;
      found_q <= 1'b0;
      k_q     <= '0;
    end else if (cmd_i.scan_step) begin
      if (unit_free && !inrun_q) begin
        inrun_q <= 1'b1;
        run_q   <= idx_q;
      end else if (!unit_free) begin
        inrun_q <= 1'b0;
      end
      if (take) begin
        found_q  <= 1'b1;
        bstart_q <= run_q;
        blen_q   <= len;
      end
      // Hold the chosen start in the counter when the scan ends.
      if (sts_o.scan_done) idx_q <= take ? run_q : bstart_q;
      else                 idx_q <= idx_q + CntW'(1);
    end else if (cmd_i.mark_step) begin
      idx_q <= idx_q + CntW'(1);
    end else if (cmd_i.look_step) begin
      if (sts_o.look_hit) begin
        fstart_q <= CntW'(tab_start_q[k_idx]);
        flen_q   <= tab_len_q[k_idx];
        bstart_q <= CntW'(tab_start_q[k_idx]);
        size_q   <= tab_len_q[k_idx];
        idx_q    <= CntW'(tab_start_q[k_idx]);
      end else begin
        k_q <= k_q + (OwnW+1)'(1);
      end
    end else if (cmd_i.shift_step) begin
      k_q <= k_q + (OwnW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      if (act_q) begin
        if (sts_o.look_done) begin
          status_q <= StNotFound; sa_q <= '0; ea_q <= '0;
        end else begin
          status_q <= StFreed;
          sa_q     <= fstart_q[7:0];
          ea_q     <= 8'(fstart_q + flen_q - CntW'(1));
        end
      end else if (sts_o.table_full) begin
        status_q <= StFull; sa_q <= '0; ea_q <= '0;
      end else if (sts_o.bad_size || !found_q) begin
        status_q <= StNoFit; sa_q <= '0; ea_q <= '0;
      end else begin
        status_q <= StAlloc;
        sa_q     <= bstart_q[7:0];
        ea_q     <= 8'(bstart_q + size_q - CntW'(1));
      end
    end
  end

  assign status_o        = status_q;
  assign start_address_o = sa_q;
  assign end_address_o   = ea_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OcntW'(MaxOwners)) else $error("table count overflow");
  a_no_alloc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_done |-> !sts_o.table_full) else $error("append to full table");
  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_step |-> cnt_q != '0) else $error("shift on empty table");
  a_mark_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> !clr_busy_q) else $error("map write during clearing");
endmodule

FILE: hdl/cfa_ctrl.sv
// Controller: sequences scan, mark, lookup, clear and table shift for each item.
module cfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output cfa_pkg::cmd_t  cmd_o,
  input  cfa_pkg::sts_t  sts_i
);
  import cfa_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   busy_q, busy_d;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_OUT;
      S_OUT:   begin
        if (sts_i.is_free) state_d = S_LOOK;
        else if (sts_i.table_full || sts_i.bad_size) state_d = S_IDLE;
        else state_d = S_SCAN;
      end
      S_SCAN:  if (sts_i.scan_done) state_d = sts_i.found ? S_MARK : S_IDLE;
      S_MARK:  if (sts_i.mark_done) state_d = S_IDLE;
      S_LOOK:  begin
        if (sts_i.look_done) state_d = S_IDLE;
        else if (sts_i.look_hit) state_d = S_CLEAR;
      end
      S_CLEAR: if (sts_i.mark_done) state_d = S_SHIFT;
      S_SHIFT: if (sts_i.shift_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    ov_d       = ov_q && out_stall;
    busy_d     = busy_q;
    cmd_o.load = accept;
    case (state_q)
      S_OUT: begin
        if (!sts_i.is_free && (sts_i.table_full || sts_i.bad_size)) begin
          cmd_o.set_result = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done && !sts_i.found) cmd_o.set_result = 1'b1;
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_done) begin
          cmd_o.alloc_done = 1'b1;
          cmd_o.set_result = 1'b1;
        end
      end
      S_LOOK: begin
        cmd_o.look_step = 1'b1;
        if (sts_i.look_done) cmd_o.set_result = 1'b1;
      end
      S_CLEAR: cmd_o.mark_step = 1'b1;
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) cmd_o.set_result = 1'b1;
      end
      default: ;
    endcase
    if (cmd_o.load) busy_d = 1'b1;
    if (cmd_o.set_result) begin
      ov_d   = 1'b1;
      busy_d = 1'b0;
    end
  end

  // A new item waits until the map is cleared and the previous result has left
  // the output register.
  assign in_stall  = (state_q != S_IDLE) || busy_q || ov_q || sts_i.clearing;
  assign out_valid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      busy_q  <= busy_d;
    end
  end

  a_res_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_result |-> !ov_q) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_OUT) else $error("load lost");
  a_scan_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !sts_i.is_free) else $error("scan on free");
endmodule

FILE: hdl/contiguous_fit_allocator_unit.sv
// Top level: contiguous fit allocator with controller and datapath.
// Channels: the input channel (in_valid/in_stall) carries action, owner id,
//   request size and policy; the output channel (out_valid/out_stall) returns
//   status, start and end address, one result per item, held while out_stall
//   is high. The configuration channel (cfg_valid/cfg_ready) writes ram_size;
//   write it only while no item is in work.
// Sequence from acceptance to out_valid, with lim = min(ram_size, 256):
//   an allocate that fits scans lim + 1 positions, then marks the block unit
//   by unit; with no fit it ends after the scan; with a full table or zero
//   size it neither scans nor marks. A free looks up the table entry by entry,
//   clears the block, then shifts the table; an unknown id ends after lookup.
// Throughput: one item in work at a time; the next item can be taken the
//   cycle after the result has been accepted, so the map scan and mark set
//   the rate.
// Reset: ram_size 256, table empty; a clearing pass after reset frees the 256
//   map units, with in_stall high meanwhile. While a result waits under
//   out_stall, in_stall stays high.
module contiguous_fit_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action_i,
  input  logic [15:0] owner_id_i,
  input  logic [8:0]  request_size_i,
  input  logic [1:0]  policy_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status_o,
  output logic [7:0]  start_address_o,
  output logic [7:0]  end_address_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  ram_size_i
);
  import cfa_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [8:0] ram_size_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ram_size_q <= 9'd256;
    else if (cfg_valid && cfg_ready) ram_size_q <= ram_size_i;
  end

  cfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_o(cmd), .sts_i(sts)
  );

  cfa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .ram_size_i(ram_size_q),
    .action_i, .owner_id_i, .request_size_i, .policy_i,
    .status_o, .start_address_o, .end_address_o
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(status_o))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status_o <= StFull) else $error("bad status");
endmodule

FILE: tb/sv/tb_contiguous_fit_allocator_unit.sv
// Testbench for the contiguous fit allocator: directed table, random traffic, scoreboard.
module tb_contiguous_fit_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  localparam int CycleLimit = 5_000_000;
  localparam int RandItems  = 1100;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] first_unit;
    logic [7:0] last_unit;
  } alloc_res_t;

  typedef struct {
    logic        cfg;     // row writes ram_size from size
    logic        act;
    logic [15:0] owner;
    logic [8:0]  size;
    logic [1:0]  pol;
    logic        known;   // expected result typed in below
    alloc_res_t  res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action_i = 1'b0;
  logic [15:0] owner_id_i = '0;
  logic [8:0]  request_size_i = '0;
  logic [1:0]  policy_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  start_address_o;
  logic [7:0]  end_address_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  ram_size_i = '0;

  contiguous_fit_allocator_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic        unit_used [MapUnits];
  logic [15:0] tbl_owner [MaxOwners];
  int unsigned tbl_start [MaxOwners];
  int unsigned tbl_len   [MaxOwners];
  int unsigned tbl_count;
  int unsigned ram_units;

  alloc_res_t pending_results[$];
  row_t       dir_rows[$];
  int         errors = 0;
  int         cycles = 0;
  int         stall_left = 0;
  int unsigned stall_roll;
  logic       cur_known = 1'b0;
  alloc_res_t cur_res = '0;
  alloc_res_t pred_res;
  alloc_res_t exp_res;

  function automatic alloc_res_t make_res(input logic [2:0] st, input int unsigned first,
                                          input int unsigned last);
    alloc_res_t r;
    r.status     = st;
    r.first_unit = first[7:0];
    r.last_unit  = last[7:0];
    return r;
  endfunction

  function automatic void set_units(input int unsigned start, input int unsigned length,
                                    input logic value);
    for (int unsigned i = 0; i < length; i++) begin
      if (start + i < MapUnits) unit_used[start + i] = value;
    end
  endfunction

  function automatic void pred_reset();
    for (int i = 0; i < MapUnits; i++) unit_used[i] = 1'b0;
    for (int i = 0; i < MaxOwners; i++) begin
      tbl_owner[i] = '0;
      tbl_start[i] = 0;
      tbl_len[i]   = 0;
    end
    tbl_count = 0;
    ram_units = 256;
  endfunction

  function automatic alloc_res_t predict(input logic a, input logic [15:0] o,
                                         input logic [8:0] s, input logic [1:0] p);
    int unsigned limit, i, run_start, best_start, best_len, len, k, j, st, ln;
    bit in_run, found, free_unit, take;
    if (a == 1'b0) begin
      if (tbl_count >= MaxOwners) return make_res(StFull, 0, 0);
      limit = (ram_units > MapUnits) ? MapUnits : ram_units;
      in_run = 1'b0; found = 1'b0; take = 1'b0;
      run_start = 0; best_start = 0; best_len = 0;
      for (i = 0; i <= limit; i++) begin
        free_unit = (i < limit) && !unit_used[i];
        if (free_unit) begin
          if (!in_run) begin
            in_run    = 1'b1;
            run_start = i;
          end
        end else if (in_run) begin
          len    = i - run_start;
          in_run = 1'b0;
          if (len >= s) begin
            if (!found)             take = 1'b1;
            else if (p == PolBest)  take = len < best_len;
            else if (p == PolWorst) take = len > best_len;
            else                    take = 1'b0;
            if (take) begin
              found      = 1'b1;
              best_start = run_start;
              best_len   = len;
            end
          end
        end
      end
      if (s == '0 || !found) return make_res(StNoFit, 0, 0);
      set_units(best_start, s, 1'b1);
      tbl_owner[tbl_count] = o;
      tbl_start[tbl_count] = best_start;
      tbl_len[tbl_count]   = s;
      tbl_count++;
      return make_res(StAlloc, best_start, best_start + s - 1);
    end
    for (k = 0; k < tbl_count; k++) begin
      if (tbl_owner[k] == o) begin
        st = tbl_start[k];
        ln = tbl_len[k];
        set_units(st, ln, 1'b0);
        for (j = k; j + 1 < tbl_count; j++) begin
          tbl_owner[j] = tbl_owner[j + 1];
          tbl_start[j] = tbl_start[j + 1];
          tbl_len[j]   = tbl_len[j + 1];
        end
        tbl_count--;
        return make_res(StFreed, st, st + ln - 1);
      end
    end
    return make_res(StNotFound, 0, 0);
  endfunction

  function automatic void add_item(input int unsigned a, input int unsigned o,
                                   input int unsigned s, input int unsigned p,
                                   input int unsigned k, input int unsigned st,
                                   input int unsigned f, input int unsigned l);
    row_t r;
    r.cfg   = 1'b0;
    r.act   = a[0];
    r.owner = o[15:0];
    r.size  = s[8:0];
    r.pol   = p[1:0];
    r.known = k[0];
    r.res   = make_res(st[2:0], f, l);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input int unsigned v);
    row_t r;
    r.cfg   = 1'b1;
    r.act   = 1'b0;
    r.owner = '0;
    r.size  = v[8:0];
    r.pol   = '0;
    r.known = 1'b0;
    r.res   = '0;
    dir_rows.push_back(r);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [8:0] pick_ram();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 9'd256;
    if (r < 85) return 9'($urandom_range(256, 1));
    if (r < 90) return 9'd0;
    return 9'($urandom_range(511, 257));
  endfunction

  task automatic wait_drain();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [8:0] v);
    wait_drain();
    ram_size_i = v;
    cfg_valid  = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic drive_item(input logic a, input logic [15:0] o, input logic [8:0] s,
                            input logic [1:0] p, input logic k, input alloc_res_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i       = a;
    owner_id_i     = o;
    request_size_i = s;
    policy_i       = p;
    cur_known      = k;
    cur_res        = r;
    in_valid       = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // Receiver: hold stall low mostly, with short and occasional long stalls.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 70) begin
        out_stall = 1'b0;
      end else if (stall_roll < 95) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(3);
      end else begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(40, 10);
      end
    end
  end

  // Scoreboard: predict at input acceptance, compare at output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) ram_units = int'(ram_size_i);
      if (in_valid && !in_stall) begin
        pred_res = predict(action_i, owner_id_i, request_size_i, policy_i);
        if (cur_known) pending_results.push_back(cur_res);
        else pending_results.push_back(pred_res);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result, status %0d", status_o);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, status_o);
            errors++;
          end
          if (start_address_o !== exp_res.first_unit) begin
            $error("start_address expected %0d actual %0d", exp_res.first_unit,
                   start_address_o);
            errors++;
          end
          if (end_address_o !== exp_res.last_unit) begin
            $error("end_address expected %0d actual %0d", exp_res.last_unit,
                   end_address_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $error("cycle limit reached with %0d results pending", pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    logic        a;
    logic [15:0] o;
    logic [8:0]  s;
    logic [1:0]  p;

    pred_reset();

    // Known rows after reset, extremes and error codes.
    add_item(0, 1, 10, 0, 1, StAlloc, 0, 9);
    add_item(0, 2, 0, 1, 1, StNoFit, 0, 0);
    add_item(0, 3, 256, 0, 1, StNoFit, 0, 0);
    add_item(1, 99, 0, 0, 1, StNotFound, 0, 0);
    add_item(1, 1, 0, 0, 1, StFreed, 0, 9);
    add_item(0, 4, 256, 1, 1, StAlloc, 0, 255);
    add_item(0, 5, 1, 2, 1, StNoFit, 0, 0);
    add_item(1, 4, 0, 0, 1, StFreed, 0, 255);
    add_cfg(0);
    add_item(0, 6, 1, 0, 1, StNoFit, 0, 0);
    add_cfg(300);
    add_item(0, 7, 256, 2, 1, StAlloc, 0, 255);
    add_item(1, 7, 5, 0, 1, StFreed, 0, 255);
    add_cfg(256);
    // Build holes and exercise each policy.
    add_item(0, 10, 20, 0, 0, 0, 0, 0);
    add_item(0, 11, 5, 0, 0, 0, 0, 0);
    add_item(0, 12, 30, 0, 0, 0, 0, 0);
    add_item(0, 13, 8, 0, 0, 0, 0, 0);
    add_item(0, 14, 40, 0, 0, 0, 0, 0);
    add_item(1, 11, 0, 0, 0, 0, 0, 0);
    add_item(1, 13, 0, 0, 0, 0, 0, 0);
    add_item(0, 15, 5, 1, 0, 0, 0, 0);
    add_item(0, 16, 4, 2, 0, 0, 0, 0);
    add_item(0, 17, 6, 3, 0, 0, 0, 0);
    add_cfg(100);
    add_item(0, 18, 50, 2, 0, 0, 0, 0);
    add_item(0, 18, 2, 1, 0, 0, 0, 0);
    add_cfg(256);
    // Fill the table with one owner, then free two of its blocks, oldest first.
    for (int n = 0; n < 12; n++) add_item(0, 20, 2, n % 4, 0, 0, 0, 0);
    add_item(0, 21, 0, 0, 0, 0, 0, 0);
    add_item(1, 20, 0, 0, 0, 0, 0, 0);
    add_item(1, 20, 0, 0, 0, 0, 0, 0);
    add_item(1, 10, 0, 0, 0, 0, 0, 0);
    add_item(1, 12, 0, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].cfg) cfg_write(dir_rows[n].size);
      else drive_item(dir_rows[n].act, dir_rows[n].owner, dir_rows[n].size,
                      dir_rows[n].pol, dir_rows[n].known, dir_rows[n].res);
    end

    for (int n = 0; n < RandItems; n++) begin
      if (n % 100 == 50) cfg_write(pick_ram());
      roll = $urandom_range(99);
      a = (roll < 55) ? 1'b0 : 1'b1;
      roll = $urandom_range(99);
      o = (roll < 90) ? 16'($urandom_range(23)) : 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 70)      s = 9'($urandom_range(32, 1));
      else if (roll < 85) s = 9'($urandom_range(128, 33));
      else if (roll < 93) s = 9'($urandom_range(256, 129));
      else if (roll < 97) s = '0;
      else                s = 9'($urandom_range(511, 257));
      p = 2'($urandom_range(3));
      drive_item(a, o, s, p, 1'b0, '0);
    end

    wait_drain();
    repeat (5) @(negedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: contiguous_fit_allocator_unit.f
hdl/cfa_pkg.sv
hdl/cfa_datapath.sv
hdl/cfa_ctrl.sv
hdl/contiguous_fit_allocator_unit.sv
tb/sv/tb_contiguous_fit_allocator_unit.sv
